// ===== design/cpnc_pkg.sv =====
// Shared constants, codes and controller/datapath interface types for the closest pair unit.
`default_nettype none

package cpnc_pkg;

    // default sizes
    localparam int MAX_POINTS_DEF = 256;
    localparam int MAX_DIMS_DEF   = 8;
    localparam int COORD_BITS_DEF = 16;

    // fixed field widths
    localparam int THR_W      = 35;
    localparam int DIMS_W     = 4;
    localparam int NEAR_W     = 15;
    localparam int IDX_W      = 8;
    localparam int MIN_W      = 35;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 35;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD_SQ = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_DIMS_IN_USE  = 1'b1;

    localparam logic [THR_W-1:0]  THRESHOLD_RESET = '0;
    localparam logic [DIMS_W-1:0] DIMS_RESET      = 4'd2;
    localparam logic [NEAR_W-1:0] NEAR_MAX        = '1;

    typedef enum logic [2:0] {
        ST_LOAD  = 3'b001,
        ST_SWEEP = 3'b010,
        ST_DRAIN = 3'b100
    } cpnc_state_t;

    typedef struct packed {
        logic load;        // coordinate transfer this cycle
        logic sweep_init;  // set closed, arm pair counters
        logic issue;       // issue one (i, j, k) read
        logic capture;     // latch result, clear set state
    } cpnc_cmd_t;

    typedef struct packed {
        logic no_pairs;    // fewer than two points stored
        logic sweep_last;  // counters sit on the final read of the sweep
        logic pipe_busy;   // distance pipeline still holds work
    } cpnc_status_t;

endpackage

`default_nettype wire

// ===== design/cpnc_ctrl.sv =====
// Controller state machine: load, pair sweep, drain and result handoff.
`default_nettype none

module cpnc_ctrl (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_valid,
    input  wire logic                   s_last_point,
    input  wire logic                   m_ready,
    input  wire cpnc_pkg::cpnc_status_t status,
    output logic                        s_ready,
    output logic                        m_valid,
    output cpnc_pkg::cpnc_cmd_t         cmd
);

    cpnc_pkg::cpnc_state_t state_reg, state_next;
    logic                  out_valid_reg, out_valid_next;

    always_comb begin
        state_next  = state_reg;
        cmd         = '0;
        s_ready     = 1'b0;
        case (state_reg)
            cpnc_pkg::ST_LOAD: begin
                s_ready        = 1'b1;
                cmd.load       = s_valid;
                cmd.sweep_init = s_valid && s_last_point;
                if (s_valid && s_last_point) begin
                    state_next = cpnc_pkg::ST_SWEEP;
                end
            end
            cpnc_pkg::ST_SWEEP: begin
                cmd.issue = !status.no_pairs;
                if (status.no_pairs || status.sweep_last) begin
                    state_next = cpnc_pkg::ST_DRAIN;
                end
            end
            cpnc_pkg::ST_DRAIN: begin
                // wait for the pipe to empty and the output register to free up
                if (!status.pipe_busy && (!out_valid_reg || m_ready)) begin
                    cmd.capture = 1'b1;
                    state_next  = cpnc_pkg::ST_LOAD;
                end
            end
            default: begin
                state_next = cpnc_pkg::ST_LOAD;
            end
        endcase
    end

    always_comb begin
        if (cmd.capture) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    assign m_valid = out_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= cpnc_pkg::ST_LOAD;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/cpnc_datapath.sv =====
// Datapath: config registers, point store, pair counters and distance pipeline.
`default_nettype none

module cpnc_datapath #(
    parameter int MAX_POINTS = cpnc_pkg::MAX_POINTS_DEF,
    parameter int MAX_DIMS   = cpnc_pkg::MAX_DIMS_DEF,
    parameter int COORD_BITS = cpnc_pkg::COORD_BITS_DEF
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                cfg_valid,
    input  wire logic [cpnc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [cpnc_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  wire logic [COORD_BITS-1:0]               s_coord,
    input  wire logic                                s_last_point,
    input  wire cpnc_pkg::cpnc_cmd_t                 cmd,
    output cpnc_pkg::cpnc_status_t                   status,
    output logic [cpnc_pkg::NEAR_W-1:0]              m_near_pairs,
    output logic [cpnc_pkg::MIN_W-1:0]               m_min_dist_sq,
    output logic [cpnc_pkg::IDX_W-1:0]               m_first_index,
    output logic [cpnc_pkg::IDX_W-1:0]               m_second_index,
    output logic                                     m_pair_found
);

    localparam int PT_W   = $clog2(MAX_POINTS);
    localparam int CNT_W  = $clog2(MAX_POINTS + 1);
    localparam int DIM_W  = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
    localparam int LEN_W  = $clog2(MAX_DIMS + 1);
    localparam int ADDR_W = PT_W + DIM_W;
    localparam int SQ_W   = 2 * COORD_BITS;
    localparam int DIST_W = SQ_W + LEN_W;
    localparam int CMP_W  = (DIST_W > cpnc_pkg::THR_W) ? DIST_W : cpnc_pkg::THR_W;

    // ---------------- configuration
    logic [cpnc_pkg::THR_W-1:0]  threshold_reg, threshold_next;
    logic [cpnc_pkg::DIMS_W-1:0] dims_reg, dims_next;
    logic [LEN_W-1:0]            eff_dims;

    always_comb begin
        threshold_next = threshold_reg;
        dims_next      = dims_reg;
        if (cfg_valid) begin
            case (cfg_index)
                cpnc_pkg::REG_THRESHOLD_SQ: threshold_next = cfg_data[cpnc_pkg::THR_W-1:0];
                cpnc_pkg::REG_DIMS_IN_USE:  dims_next      = cfg_data[cpnc_pkg::DIMS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // zero acts as one, anything above the build limit acts as the limit
    always_comb begin
        if (dims_reg == '0) begin
            eff_dims = LEN_W'(1);
        end else if (int'(dims_reg) > MAX_DIMS) begin
            eff_dims = LEN_W'(MAX_DIMS);
        end else begin
            eff_dims = LEN_W'(dims_reg);
        end
    end

    // ---------------- storage
    // per-point fill length masks stale coordinates, so no zero fill is needed
    logic [COORD_BITS-1:0] pmem [2**ADDR_W];
    logic [LEN_W-1:0]      lmem [2**PT_W];

    logic [CNT_W-1:0] pc_reg, pc_next;
    logic [DIM_W-1:0] ci_reg, ci_next;
    logic [DIM_W-1:0] ci_use;
    logic [LEN_W-1:0] fill_len;
    logic             room, finish;

    assign ci_use   = (LEN_W'(ci_reg) >= eff_dims) ? DIM_W'(eff_dims - LEN_W'(1)) : ci_reg;
    assign fill_len = LEN_W'(ci_use) + LEN_W'(1);
    assign room     = pc_reg < CNT_W'(MAX_POINTS);
    assign finish   = cmd.load && (s_last_point || (fill_len >= eff_dims));

    always_comb begin
        pc_next = pc_reg;
        ci_next = ci_reg;
        if (cmd.capture) begin
            pc_next = '0;
            ci_next = '0;
        end else if (finish) begin
            ci_next = '0;
            if (room) begin
                pc_next = pc_reg + CNT_W'(1);
            end
        end else if (cmd.load) begin
            ci_next = DIM_W'(fill_len);
        end
    end

    // ---------------- pair counters
    logic [PT_W-1:0]  i_reg, i_next, j_reg, j_next;
    logic [DIM_W-1:0] k_reg, k_next;
    logic             k_last, j_end, i_end;

    assign k_last = (LEN_W'(k_reg) + LEN_W'(1)) == eff_dims;
    assign j_end  = (CNT_W'(j_reg) + CNT_W'(1)) == pc_reg;
    assign i_end  = (CNT_W'(i_reg) + CNT_W'(2)) == pc_reg;

    always_comb begin
        i_next = i_reg;
        j_next = j_reg;
        k_next = k_reg;
        if (cmd.sweep_init) begin
            i_next = '0;
            j_next = PT_W'(1);
            k_next = '0;
        end else if (cmd.issue) begin
            if (!k_last) begin
                k_next = k_reg + DIM_W'(1);
            end else begin
                k_next = '0;
                if (!j_end) begin
                    j_next = j_reg + PT_W'(1);
                end else begin
                    i_next = i_reg + PT_W'(1);
                    j_next = i_reg + PT_W'(2);
                end
            end
        end
    end

    // ---------------- distance pipeline
    logic [COORD_BITS-1:0] xa_reg, xb_reg, diff_reg;
    logic [LEN_W-1:0]      la_reg, lb_reg;
    logic [SQ_W-1:0]       sq_reg;
    logic [DIST_W-1:0]     acc_reg, sum;
    logic                  s1_valid, s2_valid, s3_valid;
    logic                  s1_first, s2_first, s3_first;
    logic                  s1_last, s2_last, s3_last;
    logic [DIM_W-1:0]      s1_k;
    logic [PT_W-1:0]       s1_i, s2_i, s3_i, s1_j, s2_j, s3_j;
    logic [COORD_BITS-1:0] ma, mb;

    assign ma  = (LEN_W'(s1_k) < la_reg) ? xa_reg : '0;
    assign mb  = (LEN_W'(s1_k) < lb_reg) ? xb_reg : '0;
    assign sum = (s3_first ? '0 : acc_reg) + DIST_W'(sq_reg);

    assign status.no_pairs   = pc_reg < CNT_W'(2);
    assign status.sweep_last = k_last && j_end && i_end;
    assign status.pipe_busy  = s1_valid || s2_valid || s3_valid;

    // ---------------- set results
    logic [cpnc_pkg::NEAR_W-1:0] near_reg, near_next;
    logic [DIST_W-1:0]           best_reg, best_next;
    logic [PT_W-1:0]             best_first_reg, best_first_next;
    logic [PT_W-1:0]             best_second_reg, best_second_next;
    logic [CMP_W-1:0]            best_ext;
    logic                        found;

    always_comb begin
        near_next        = near_reg;
        best_next        = best_reg;
        best_first_next  = best_first_reg;
        best_second_next = best_second_reg;
        if (cmd.capture) begin
            near_next        = '0;
            best_next        = '1;
            best_first_next  = '0;
            best_second_next = '0;
        end else if (s3_valid && s3_last) begin
            if ((CMP_W'(sum) < CMP_W'(threshold_reg)) && (near_reg != cpnc_pkg::NEAR_MAX)) begin
                near_next = near_reg + cpnc_pkg::NEAR_W'(1);
            end
            // strict compare: earliest pair in sweep order keeps a tie
            if (sum < best_reg) begin
                best_next        = sum;
                best_first_next  = s3_i;
                best_second_next = s3_j;
            end
        end
    end

    assign best_ext = CMP_W'(best_reg);
    assign found    = pc_reg >= CNT_W'(2);

    // ---------------- clocked
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            threshold_reg   <= cpnc_pkg::THRESHOLD_RESET;
            dims_reg        <= cpnc_pkg::DIMS_RESET;
            pc_reg          <= '0;
            ci_reg          <= '0;
            near_reg        <= '0;
            best_reg        <= '1;
            best_first_reg  <= '0;
            best_second_reg <= '0;
            s1_valid        <= 1'b0;
            s2_valid        <= 1'b0;
            s3_valid        <= 1'b0;
        end else begin
            threshold_reg   <= threshold_next;
            dims_reg        <= dims_next;
            pc_reg          <= pc_next;
            ci_reg          <= ci_next;
            near_reg        <= near_next;
            best_reg        <= best_next;
            best_first_reg  <= best_first_next;
            best_second_reg <= best_second_next;
            s1_valid        <= cmd.issue;
            s2_valid        <= s1_valid;
            s3_valid        <= s2_valid;
        end
    end

    always_ff @(posedge aclk) begin
        i_reg <= i_next;
        j_reg <= j_next;
        k_reg <= k_next;
    end

    // point store: one write port, two registered read ports
    always_ff @(posedge aclk) begin
        if (cmd.load && room) begin
            pmem[{pc_reg[PT_W-1:0], ci_use}] <= s_coord;
        end
        if (cmd.issue) begin
            xa_reg <= pmem[{i_reg, k_reg}];
            xb_reg <= pmem[{j_reg, k_reg}];
        end
    end

    always_ff @(posedge aclk) begin
        if (finish && room) begin
            lmem[pc_reg[PT_W-1:0]] <= fill_len;
        end
        if (cmd.issue) begin
            la_reg <= lmem[i_reg];
            lb_reg <= lmem[j_reg];
        end
    end

    always_ff @(posedge aclk) begin
        s1_first <= (k_reg == '0);
        s1_last  <= k_last;
        s1_k     <= k_reg;
        s1_i     <= i_reg;
        s1_j     <= j_reg;

        diff_reg <= (ma > mb) ? (ma - mb) : (mb - ma);
        s2_first <= s1_first;
        s2_last  <= s1_last;
        s2_i     <= s1_i;
        s2_j     <= s1_j;

        sq_reg   <= SQ_W'(diff_reg) * SQ_W'(diff_reg);
        s3_first <= s2_first;
        s3_last  <= s2_last;
        s3_i     <= s2_i;
        s3_j     <= s2_j;

        if (s3_valid) begin
            acc_reg <= sum;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            m_near_pairs   <= found ? near_reg : '0;
            m_min_dist_sq  <= found ? best_ext[cpnc_pkg::MIN_W-1:0] : '0;
            m_first_index  <= found ? cpnc_pkg::IDX_W'(best_first_reg) : '0;
            m_second_index <= found ? cpnc_pkg::IDX_W'(best_second_reg) : '0;
            m_pair_found   <= found;
        end
    end

endmodule

`default_nettype wire

// ===== design/closest_pair_and_near_count_unit.sv =====
// Top level of the closest pair and near pair count unit.
//
//  channel  | handshake            | payload
//  ---------+----------------------+---------------------------------------------------
//  cfg      | cfg_valid/cfg_ready  | cfg_index, cfg_data (0 threshold_sq, 1 dims_in_use)
//  input    | s_valid/s_ready      | s_coord, s_last_point
//  result   | m_valid/m_ready      | m_near_pairs, m_min_dist_sq, m_first_index,
//           |                      | m_second_index, m_pair_found
//
// Loading takes one coordinate transfer per cycle; cfg_ready is always high.
// The s_last_point transfer starts the sweep, one coordinate pair per cycle over each
// effective dim of every pair of stored points; the pipe then drains for capture.
// A set with fewer than two points issues no reads. s_ready is low from the closing
// transfer until capture; capture also waits while an earlier result is still unaccepted.
// Reset clears control and config state, not the store; fill lengths mask stale entries.
`default_nettype none

module closest_pair_and_near_count_unit #(
    parameter int MAX_POINTS = cpnc_pkg::MAX_POINTS_DEF,
    parameter int MAX_DIMS   = cpnc_pkg::MAX_DIMS_DEF,
    parameter int COORD_BITS = cpnc_pkg::COORD_BITS_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // configuration writes
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [cpnc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [cpnc_pkg::CFG_DATA_W-1:0] cfg_data,
    // coordinate stream
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic [COORD_BITS-1:0]           s_coord,
    input  wire logic                            s_last_point,
    // result
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic [cpnc_pkg::NEAR_W-1:0]          m_near_pairs,
    output logic [cpnc_pkg::MIN_W-1:0]           m_min_dist_sq,
    output logic [cpnc_pkg::IDX_W-1:0]           m_first_index,
    output logic [cpnc_pkg::IDX_W-1:0]           m_second_index,
    output logic                                 m_pair_found
);

    cpnc_pkg::cpnc_cmd_t    cmd;
    cpnc_pkg::cpnc_status_t status;

    // registers take a write in any cycle
    assign cfg_ready = 1'b1;

    // sequencing: load / sweep / drain, plus the output valid flag
    cpnc_ctrl u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_last_point (s_last_point),
        .m_ready      (m_ready),
        .status       (status),
        .s_ready      (s_ready),
        .m_valid      (m_valid),
        .cmd          (cmd)
    );

    // storage, pair counters, distance pipe, best/near tracking, output register
    cpnc_datapath #(
        .MAX_POINTS (MAX_POINTS),
        .MAX_DIMS   (MAX_DIMS),
        .COORD_BITS (COORD_BITS)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_coord        (s_coord),
        .s_last_point   (s_last_point),
        .cmd            (cmd),
        .status         (status),
        .m_near_pairs   (m_near_pairs),
        .m_min_dist_sq  (m_min_dist_sq),
        .m_first_index  (m_first_index),
        .m_second_index (m_second_index),
        .m_pair_found   (m_pair_found)
    );

endmodule

`default_nettype wire

// ===== design/cpnc_checker.sv =====
// Port-level assertions for the closest pair unit and the bind that attaches them.
`default_nettype none

module cpnc_checker #(
    parameter int MAX_POINTS = cpnc_pkg::MAX_POINTS_DEF
) (
    input wire logic                       aclk,
    input wire logic                       aresetn,
    input wire logic                       s_valid,
    input wire logic                       s_ready,
    input wire logic                       s_last_point,
    input wire logic                       m_valid,
    input wire logic                       m_ready,
    input wire logic [cpnc_pkg::NEAR_W-1:0] m_near_pairs,
    input wire logic [cpnc_pkg::MIN_W-1:0]  m_min_dist_sq,
    input wire logic [cpnc_pkg::IDX_W-1:0]  m_first_index,
    input wire logic [cpnc_pkg::IDX_W-1:0]  m_second_index,
    input wire logic                       m_pair_found
);

    // no result out of reset
    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_near_pairs)
            && $stable(m_min_dist_sq) && $stable(m_first_index)
            && $stable(m_second_index) && $stable(m_pair_found)))
        else $error("stalled result changed");

    // closing transfer of a set stops intake while the sweep runs
    a_sweep_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_last_point) |=> !s_ready)
        else $error("input taken during pair sweep");

    // no pair means an all-zero result
    a_empty_set: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_pair_found) |-> (m_near_pairs == '0 && m_min_dist_sq == '0
            && m_first_index == '0 && m_second_index == '0))
        else $error("result fields set without a pair");

    // closest pair comes out in index order, checked only up to 256 points
    a_index_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_pair_found) |-> ((MAX_POINTS > 256) || (m_first_index < m_second_index)))
        else $error("closest pair indices out of order");

endmodule

bind closest_pair_and_near_count_unit cpnc_checker #(.MAX_POINTS(MAX_POINTS)) u_cpnc_checker (.*);

`default_nettype wire
